[sv/placement_candidate_scorer_core_macros.svh]
// Assertion macros for the placement candidate scorer
`ifndef PLACEMENT_CANDIDATE_SCORER_CORE_MACROS_SVH
`define PLACEMENT_CANDIDATE_SCORER_CORE_MACROS_SVH

// same-cycle implication, reset masked
`define PCS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset masked
`define PCS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/pcs_pkg.sv]
// Shared types and constants of the placement candidate scorer
`timescale 1ns / 1ps
package pcs_pkg;

  localparam logic [63:0] HashMul  = 64'd15879638260049341073;
  localparam logic [63:0] HashAdd  = 64'd5277654339219660263;
  localparam logic [31:0] HashModA = 32'd2404975667;
  localparam logic [31:0] HashModB = 32'd3414420799;
  localparam logic [64:0] TwoPow64 = 65'd1 << 64;
  // low words of floor(2^64 / modulus); the dropped top bit weighs 2^32
  localparam logic [31:0] HashRecipA = 32'(TwoPow64 / {33'd0, HashModA});
  localparam logic [31:0] HashRecipB = 32'(TwoPow64 / {33'd0, HashModB});
  localparam logic [35:0] BloomBits  = 36'd256;
  localparam logic [35:0] MatchBonus = 36'd100;
  // ceil(2^35 / 10): exact floor division by ten for any 32-bit value
  localparam logic [31:0] RecipTen   = 32'hCCCCCCCD;
  localparam int          RecipShift = 35;
  localparam int          SqrtSteps  = 32;

  typedef enum logic [2:0] {
    REG_QUERY_INDEX = 3'd0,
    REG_QUERY_START = 3'd1,
    REG_QUERY_END   = 3'd2,
    REG_WRITE_SIZE  = 3'd3,
    REG_BYTE_LIMIT  = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_MUL,
    HS_FOLD,
    HS_QUOT,
    HS_REM,
    HS_FIX
  } hash_state_t;

  // per-entry data that rides along the root chain
  typedef struct packed {
    logic [63:0]        file;
    logic               elig;
    logic signed [35:0] base;
  } item_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] rem;
    logic [63:0] root;
    item_t       item;
  } sq_t;

endpackage

[sv/pcs_in_if.sv]
// Input channel carrying one catalog entry per transaction
`timescale 1ns / 1ps
interface pcs_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] entry_file;
  logic [63:0] entry_bytes;
  logic [31:0] entry_segments;
  logic [63:0] range_low;
  logic [63:0] range_high;
  logic [63:0] bloom_word0;
  logic [63:0] bloom_word1;
  logic [63:0] bloom_word2;
  logic [63:0] bloom_word3;

  modport source (output valid, entry_file, entry_bytes, entry_segments, range_low,
                  range_high, bloom_word0, bloom_word1, bloom_word2, bloom_word3,
                  input ready);
  modport sink (input valid, entry_file, entry_bytes, entry_segments, range_low,
                range_high, bloom_word0, bloom_word1, bloom_word2, bloom_word3,
                output ready);
endinterface

[sv/pcs_out_if.sv]
// Result channel carrying one scored entry per transaction
`timescale 1ns / 1ps
interface pcs_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] scored_file;
  logic        eligible;
  logic [31:0] score;

  modport source (output valid, scored_file, eligible, score, input ready);
  modport sink (input valid, scored_file, eligible, score, output ready);
endinterface

[sv/placement_candidate_scorer_core.sv]
// Top level of the placement candidate scorer
// Pipeline from input transaction to result: entry stage, 32 root cells, divide-by-ten multiply,
//   output register; throughput one entry per cycle while the pipeline advances and the hash unit is idle.
// The whole pipeline advances together whenever the output register is free or taken.
// After reset and after each write of query_index the hash unit runs 4 multiply steps, fold,
//   quotient estimate, remainder and 2 corrections with in_ready low.
// Reset is synchronous, active low; it clears the request registers and valid flags.
`timescale 1ns / 1ps
`include "placement_candidate_scorer_core_macros.svh"
module placement_candidate_scorer_core (
  input  logic        clk,
  input  logic        rst_n,
  pcs_in_if.sink      in_ch,
  pcs_out_if.source   out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  logic [15:0] query_index_r;
  logic [63:0] query_start_r, query_end_r, byte_limit_r;
  logic [31:0] write_size_r;
  logic        cfg_wr;
  logic        hash_start, hash_busy;
  logic [7:0]  pos_a, pos_b;
  pcs_pkg::reg_idx_t reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = pcs_pkg::reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && (paddr[2:0] == 3'd0);
  assign hash_start = cfg_wr && (reg_idx == pcs_pkg::REG_QUERY_INDEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      query_index_r <= '0;
      query_start_r <= '0;
      query_end_r   <= '0;
      write_size_r  <= '0;
      byte_limit_r  <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        pcs_pkg::REG_QUERY_INDEX: query_index_r <= pwdata[15:0];
        pcs_pkg::REG_QUERY_START: query_start_r <= pwdata;
        pcs_pkg::REG_QUERY_END:   query_end_r   <= pwdata;
        pcs_pkg::REG_WRITE_SIZE:  write_size_r  <= pwdata[31:0];
        pcs_pkg::REG_BYTE_LIMIT:  byte_limit_r  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2:0] == 3'd0) begin
      case (reg_idx)
        pcs_pkg::REG_QUERY_INDEX: prdata = {48'd0, query_index_r};
        pcs_pkg::REG_QUERY_START: prdata = query_start_r;
        pcs_pkg::REG_QUERY_END:   prdata = query_end_r;
        pcs_pkg::REG_WRITE_SIZE:  prdata = {32'd0, write_size_r};
        pcs_pkg::REG_BYTE_LIMIT:  prdata = byte_limit_r;
        default:                  prdata = '0;
      endcase
    end
  end

  pcs_hash u_hash (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (hash_start),
    .query_index (query_index_r),
    .busy        (hash_busy),
    .pos_a       (pos_a),
    .pos_b       (pos_b)
  );

  // pipeline advance
  logic out_valid_r;
  logic en, in_acc;

  assign en       = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && !hash_busy;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // entry stage: eligibility, distance, popcount, bonus, segments
  logic [255:0]       bloom;
  logic [64:0]        byte_sum;
  logic [63:0]        blk_dist;
  logic [8:0]         ones;
  logic               bonus;
  pcs_pkg::sq_t       s0_nxt, s0_r;

  assign bloom    = {in_ch.bloom_word3, in_ch.bloom_word2, in_ch.bloom_word1,
                     in_ch.bloom_word0};
  assign byte_sum = {1'b0, in_ch.entry_bytes} + {33'd0, write_size_r};
  assign ones     = 9'($countones(bloom));
  assign bonus    = bloom[pos_a] && bloom[pos_b];

  always_comb begin
    blk_dist = '0;
    if (in_ch.entry_segments != 32'd0) begin
      if (query_end_r < in_ch.range_low) blk_dist = in_ch.range_low - query_end_r;
      else if (query_start_r > in_ch.range_high) blk_dist = query_start_r - in_ch.range_high;
    end
    s0_nxt.valid     = in_acc;
    s0_nxt.rem       = blk_dist;
    s0_nxt.root      = '0;
    s0_nxt.item.file = in_ch.entry_file;
    s0_nxt.item.elig = (byte_sum <= {1'b0, byte_limit_r});
    s0_nxt.item.base = $signed(pcs_pkg::BloomBits) - $signed({27'd0, ones})
                       + $signed(bonus ? pcs_pkg::MatchBonus : 36'd0)
                       - $signed({4'd0, in_ch.entry_segments});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_r.valid <= 1'b0;
    end else if (en) begin
      s0_r.valid <= s0_nxt.valid;
    end
    if (en) begin
      s0_r.rem  <= s0_nxt.rem;
      s0_r.root <= s0_nxt.root;
      s0_r.item <= s0_nxt.item;
    end
  end

  // root chain
  pcs_pkg::sq_t chain [pcs_pkg::SqrtSteps+1];
  assign chain[0] = s0_r;

  genvar k;
  generate
    for (k = 0; k < pcs_pkg::SqrtSteps; k++) begin : g_cell
      pcs_sqrt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .step_bit (64'(64'd1 << (62 - 2 * k))),
        .d_in     (chain[k]),
        .d_out    (chain[k+1])
      );
    end
  endgenerate

  // divide root by ten through the reciprocal
  logic          dv_valid_r;
  logic [63:0]   dv_prod_r;
  pcs_pkg::item_t dv_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_valid_r <= 1'b0;
    end else if (en) begin
      dv_valid_r <= chain[pcs_pkg::SqrtSteps].valid;
    end
    if (en) begin
      dv_prod_r <= chain[pcs_pkg::SqrtSteps].root[31:0] * pcs_pkg::RecipTen;
      dv_item_r <= chain[pcs_pkg::SqrtSteps].item;
    end
  end

  // final score and saturation
  logic [28:0]        quot;
  logic signed [35:0] raw;
  logic [31:0]        score_nxt;
  logic [63:0]        file_r;
  logic               elig_r;
  logic [31:0]        score_r;

  assign quot = dv_prod_r[63:pcs_pkg::RecipShift];
  assign raw  = dv_item_r.base - $signed({7'd0, quot});

  always_comb begin
    if (raw < -36'sd2147483648) score_nxt = 32'h8000_0000;
    else                        score_nxt = raw[31:0];
    if (!dv_item_r.elig) score_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid_r;
    end
    if (en) begin
      file_r  <= dv_item_r.file;
      elig_r  <= dv_item_r.elig;
      score_r <= score_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scored_file = file_r;
  assign out_ch.eligible    = elig_r;
  assign out_ch.score       = score_r;

  `PCS_ASSERT_IMP(a_busy_blocks_input, hash_busy, !in_ch.ready, "input taken during hash")
  `PCS_ASSERT_NXT(a_index_write_rehash, hash_start, !in_ch.ready, "no rehash after index write")
  `PCS_ASSERT_IMP(a_inelig_zero, out_valid_r && !elig_r, score_r == 32'd0, "ineligible nonzero")
  `PCS_ASSERT_IMP(a_score_max, out_valid_r, $signed(score_r) <= 32'sd356, "score above maximum")

endmodule

[sv/pcs_hash.sv]
// Sequential bloom hash unit: multiply-add, then two reciprocal-based remainders
`timescale 1ns / 1ps
module pcs_hash (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] query_index,
  output logic        busy,
  output logic [7:0]  pos_a,
  output logic [7:0]  pos_b
);

  pcs_pkg::hash_state_t state_r, state_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] ya_r, ya_nxt, yb_r, yb_nxt;
  logic [31:0] qa_r, qa_nxt, qb_r, qb_nxt;
  logic [15:0] mul_slice;
  logic [31:0] pp;
  logic [63:0] pa, pb;
  logic [63:0] sa, sb;
  logic [63:0] ma, mb;

  function automatic logic [31:0] fold_hi(input logic [31:0] w, input logic [31:0] m);
    return (w >= m) ? w - m : w;
  endfunction

  function automatic logic [63:0] fix_rem(input logic [63:0] y, input logic [31:0] m);
    return (y >= {32'd0, m}) ? y - {32'd0, m} : y;
  endfunction

  assign mul_slice = 16'(pcs_pkg::HashMul >> {cnt_r, 4'b0});
  assign pp        = query_index * mul_slice;

  // quotient estimate: high word times the reciprocal, low product dropped
  assign pa = ya_r[63:32] * pcs_pkg::HashRecipA;
  assign pb = yb_r[63:32] * pcs_pkg::HashRecipB;
  assign sa = pa + {32'd0, ya_r[31:0]};
  assign sb = pb + {32'd0, yb_r[31:0]};
  assign ma = qa_r * pcs_pkg::HashModA;
  assign mb = qb_r * pcs_pkg::HashModB;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    acc_nxt   = acc_r;
    ya_nxt    = ya_r;
    yb_nxt    = yb_r;
    qa_nxt    = qa_r;
    qb_nxt    = qb_r;
    case (state_r)
      pcs_pkg::HS_MUL: begin
        acc_nxt = acc_r + 64'({32'd0, pp} << {cnt_r, 4'b0});
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) state_nxt = pcs_pkg::HS_FOLD;
      end
      pcs_pkg::HS_FOLD: begin
        // bring the high word below the modulus
        ya_nxt    = {fold_hi(acc_r[63:32], pcs_pkg::HashModA), acc_r[31:0]};
        yb_nxt    = {fold_hi(acc_r[63:32], pcs_pkg::HashModB), acc_r[31:0]};
        state_nxt = pcs_pkg::HS_QUOT;
      end
      pcs_pkg::HS_QUOT: begin
        qa_nxt    = ya_r[63:32] + sa[63:32];
        qb_nxt    = yb_r[63:32] + sb[63:32];
        state_nxt = pcs_pkg::HS_REM;
      end
      pcs_pkg::HS_REM: begin
        ya_nxt    = ya_r - ma;
        yb_nxt    = yb_r - mb;
        cnt_nxt   = '0;
        state_nxt = pcs_pkg::HS_FIX;
      end
      pcs_pkg::HS_FIX: begin
        // estimate is low by at most two
        ya_nxt  = fix_rem(ya_r, pcs_pkg::HashModA);
        yb_nxt  = fix_rem(yb_r, pcs_pkg::HashModB);
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd1) state_nxt = pcs_pkg::HS_IDLE;
      end
      default: ;
    endcase
    if (start) begin
      state_nxt = pcs_pkg::HS_MUL;
      cnt_nxt   = '0;
      acc_nxt   = pcs_pkg::HashAdd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pcs_pkg::HS_MUL;
      cnt_r   <= '0;
      acc_r   <= pcs_pkg::HashAdd;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      acc_r   <= acc_nxt;
    end
    ya_r <= ya_nxt;
    yb_r <= yb_nxt;
    qa_r <= qa_nxt;
    qb_r <= qb_nxt;
  end

  assign busy  = (state_r != pcs_pkg::HS_IDLE);
  assign pos_a = ya_r[7:0];
  assign pos_b = yb_r[7:0];

endmodule

[sv/pcs_sqrt_cell.sv]
// One cell of the square-root chain: resolves one root bit per entry
`timescale 1ns / 1ps
module pcs_sqrt_cell (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [63:0]  step_bit,
  input  pcs_pkg::sq_t d_in,
  output pcs_pkg::sq_t d_out
);

  pcs_pkg::sq_t d_r, d_nxt;
  logic [63:0]  trial;

  assign trial = d_in.root + step_bit;

  always_comb begin
    d_nxt = d_in;
    if (d_in.rem >= trial) begin
      d_nxt.rem  = d_in.rem - trial;
      d_nxt.root = (d_in.root >> 1) + step_bit;
    end else begin
      d_nxt.root = d_in.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r.valid <= 1'b0;
    end else if (en) begin
      d_r.valid <= d_nxt.valid;
    end
    if (en) begin
      d_r.rem  <= d_nxt.rem;
      d_r.root <= d_nxt.root;
      d_r.item <= d_nxt.item;
    end
  end

  assign d_out = d_r;

endmodule
